[rtl/core/gcr_pkg.sv]
// gcr_pkg: shared widths, register codes, reset values and helpers of the color ramp sampler
`default_nettype none

package gcr_pkg;

   // data widths
   localparam int POS_W        = 16;
   localparam int CHAN_W       = 8;
   localparam int NUM_CHAN     = 4;
   localparam int STOP_W       = POS_W + NUM_CHAN * CHAN_W;
   localparam int CNT_W        = 3;
   localparam int NUM_STOPS_DEF = 7;

   // divider shape: quotient is a byte, numerator is span-scaled byte
   localparam int QUOT_W       = CHAN_W;
   localparam int NUM_W        = POS_W + QUOT_W;
   localparam int DIV_STEP     = 2;
   localparam int DIV_STAGES   = QUOT_W / DIV_STEP;

   // front stages (input, search, select, multiply) plus divider stages
   localparam int PIPE_LATENCY = 4 + DIV_STAGES;

   // register port
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 6;
   localparam int REG_IDX_W    = 3;
   localparam int REG_LSB      = CSR_ADDR_W - REG_IDX_W;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_STOP_BASE  = REG_IDX_W'(1);

   // reset values
   localparam logic [CNT_W-1:0]  CNT_RESET   = CNT_W'(2);
   localparam logic [STOP_W-1:0] STOP0_RESET = STOP_W'(255);
   localparam logic [STOP_W-1:0] STOP1_RESET = {STOP_W{1'b1}};

   typedef logic [NUM_CHAN-1:0][NUM_W-1:0]  num_vec_type;
   typedef logic [NUM_CHAN-1:0][QUOT_W-1:0] quot_vec_type;

   // one transfer into the divider: four numerators sharing one span
   typedef struct packed {
      num_vec_type       num;
      logic [POS_W-1:0]  span;
   } div_req_type;

   function automatic logic [STOP_W-1:0] stop_reset(input int k);
      logic [STOP_W-1:0] val;
      case (k)
         0:       val = STOP0_RESET;
         1:       val = STOP1_RESET;
         default: val = '0;
      endcase
      return val;
   endfunction

   function automatic logic [POS_W-1:0] stop_pos(input logic [STOP_W-1:0] w);
      return w[STOP_W-1 -: POS_W];
   endfunction

   // channel 0 is red in the top byte, channel 3 alpha in the low byte
   function automatic logic [CHAN_W-1:0] stop_chan(input logic [STOP_W-1:0] w, input int ch);
      return w[(NUM_CHAN-1-ch)*CHAN_W +: CHAN_W];
   endfunction

endpackage

`default_nettype wire

[rtl/core/gcr_divider.sv]
// gcr_divider: pipelined restoring divider, four lanes with a shared divisor, byte quotient
`default_nettype none

module gcr_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire gcr_pkg::div_req_type in_req,
   output logic                      out_valid,
   output gcr_pkg::quot_vec_type     out_quot
);
   import gcr_pkg::*;

   // rem holds the partial remainder, bits shifts numerator bits out and quotient bits in
   typedef struct packed {
      logic [NUM_CHAN-1:0][POS_W-1:0]  rem;
      logic [NUM_CHAN-1:0][QUOT_W-1:0] bits;
      logic [POS_W-1:0]                span;
   } div_stage_type;

   logic [DIV_STAGES-1:0] valid_ff;
   div_stage_type         stage_ff  [DIV_STAGES];
   div_stage_type         stage_src [DIV_STAGES];
   div_stage_type         stage_in  [DIV_STAGES];
   logic [DIV_STAGES-1:0] valid_src;

   // entry: the top part of the numerator is already below the span
   div_stage_type entry;
   always_comb begin
      for (int ln = 0; ln < NUM_CHAN; ln++) begin
         entry.rem[ln]  = in_req.num[ln][NUM_W-1 -: POS_W];
         entry.bits[ln] = in_req.num[ln][QUOT_W-1:0];
      end
      entry.span = in_req.span;
   end

   genvar s;
   generate
      for (s = 0; s < DIV_STAGES; s++) begin : g_stage
         if (s == 0) begin : g_first
            assign stage_src[s] = entry;
            assign valid_src[s] = in_valid;
         end else begin : g_next
            assign stage_src[s] = stage_ff[s-1];
            assign valid_src[s] = valid_ff[s-1];
         end

         // DIV_STEP compare-subtract steps per lane
         always_comb begin
            logic [POS_W:0]   trial;
            logic [POS_W-1:0] rem;
            logic [QUOT_W-1:0] bits;
            stage_in[s] = stage_src[s];
            for (int ln = 0; ln < NUM_CHAN; ln++) begin
               rem  = stage_src[s].rem[ln];
               bits = stage_src[s].bits[ln];
               for (int st = 0; st < DIV_STEP; st++) begin
                  trial = {rem, bits[QUOT_W-1]};
                  if (trial >= {1'b0, stage_src[s].span}) begin
                     rem  = POS_W'(trial - {1'b0, stage_src[s].span});
                     bits = {bits[QUOT_W-2:0], 1'b1};
                  end else begin
                     rem  = trial[POS_W-1:0];
                     bits = {bits[QUOT_W-2:0], 1'b0};
                  end
               end
               stage_in[s].rem[ln]  = rem;
               stage_in[s].bits[ln] = bits;
            end
         end

         // stage registers
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else begin
               valid_ff[s] <= valid_src[s];
            end
            stage_ff[s] <= stage_in[s];
         end
      end
   endgenerate

   // after the last stage the shifted bits are the quotient
   assign out_valid = valid_ff[DIV_STAGES-1];
   always_comb begin
      for (int ln = 0; ln < NUM_CHAN; ln++) begin
         out_quot[ln] = stage_ff[DIV_STAGES-1].bits[ln];
      end
   end

   // quotient must fit a byte: the upper numerator part sits below the span
   a_num_fits: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (in_req.num[0][NUM_W-1 -: POS_W] < in_req.span) &&
                   (in_req.num[NUM_CHAN-1][NUM_W-1 -: POS_W] < in_req.span))
      else $error("divider numerator too large for a byte quotient");

   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> in_req.span != '0)
      else $error("divider span is zero");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##DIV_STAGES out_valid)
      else $error("divider lost a transfer");

endmodule

`default_nettype wire

[rtl/core/gradient_color_ramp_sampler.sv]
// gradient_color_ramp_sampler: top level, stop registers, stop search, mix and divide pipeline
//
// Maps a 16-bit fractional position to an RGBA byte color from a ramp of up to
// MAX_STOPS color stops held in registers.
// Input: a position is taken at a rising edge with start high and busy low. busy
// stays low, so a new position can be taken every cycle.
// Output: each color is on rsp_red/green/blue/alpha for one cycle with rsp_valid
// high. Results come out in order, through the input register, stop compare,
// stop select, channel multiply, then a four-stage divider that resolves two
// quotient bits per stage. The receiver cannot stall.
// Throughput is one color per cycle.
// Registers: stop_count at byte address 0, stop_0..stop_6 at 8..56, 64-bit data,
// position in bits 47..32, RGBA in bits 31..0. Write them only while no position
// is in flight.
// Reset: stop_count 2, stop_0 opaque black at 0, stop_1 opaque white at 65535,
// other stops zero; the pipeline is emptied.
`default_nettype none

module gradient_color_ramp_sampler #(
   parameter int MAX_STOPS = gcr_pkg::NUM_STOPS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [gcr_pkg::POS_W-1:0]     req_position,
   output logic                               rsp_valid,
   output logic [gcr_pkg::CHAN_W-1:0]         rsp_red,
   output logic [gcr_pkg::CHAN_W-1:0]         rsp_green,
   output logic [gcr_pkg::CHAN_W-1:0]         rsp_blue,
   output logic [gcr_pkg::CHAN_W-1:0]         rsp_alpha,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [gcr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [gcr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gcr_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import gcr_pkg::*;

   // register file
   logic [CNT_W-1:0]     count_ff;
   logic [STOP_W-1:0]    stop_ff [MAX_STOPS];
   logic                 csr_write;
   logic [REG_IDX_W-1:0] reg_idx;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_write = psel & penable & pwrite;
   assign reg_idx   = paddr[CSR_ADDR_W-1:REG_LSB];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_RESET;
         for (int k = 0; k < MAX_STOPS; k++) begin
            stop_ff[k] <= stop_reset(k);
         end
      end else if (csr_write) begin
         if (reg_idx == REG_STOP_COUNT) begin
            count_ff <= pwdata[CNT_W-1:0];
         end
         for (int k = 0; k < MAX_STOPS; k++) begin
            if (reg_idx == REG_STOP_BASE + REG_IDX_W'(k)) begin
               stop_ff[k] <= pwdata[STOP_W-1:0];
            end
         end
      end
   end

   // register readback
   always_comb begin
      prdata = '0;
      if (reg_idx == REG_STOP_COUNT) begin
         prdata = CSR_DATA_W'(count_ff);
      end
      for (int k = 0; k < MAX_STOPS; k++) begin
         if (reg_idx == REG_STOP_BASE + REG_IDX_W'(k)) begin
            prdata = CSR_DATA_W'(stop_ff[k]);
         end
      end
   end

   // stops in use: zero counts as one, saturate at MAX_STOPS
   logic [CNT_W-1:0] used_n;
   always_comb begin
      if (count_ff == '0) begin
         used_n = CNT_W'(1);
      end else if (count_ff > CNT_W'(MAX_STOPS)) begin
         used_n = CNT_W'(MAX_STOPS);
      end else begin
         used_n = count_ff;
      end
   end

   // stage 0: input register
   logic             accept;
   logic             s0_valid_ff;
   logic [POS_W-1:0] s0_pos_ff;

   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
      s0_pos_ff <= req_position;
   end

   // stage 1: compare against every stop in use, take the first one above the position
   logic [MAX_STOPS-1:0] above;
   logic [MAX_STOPS-1:0] s1_first_in;
   logic [MAX_STOPS-1:0] s1_last_in;
   logic                 s1_valid_ff;
   logic [POS_W-1:0]     s1_pos_ff;
   logic [MAX_STOPS-1:0] s1_first_ff;
   logic [MAX_STOPS-1:0] s1_last_ff;

   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int k = 0; k < MAX_STOPS; k++) begin
         above[k]       = (CNT_W'(k) < used_n) && (stop_pos(stop_ff[k]) > s0_pos_ff);
         s1_first_in[k] = above[k] & ~seen;
         seen           = seen | above[k];
         s1_last_in[k]  = (CNT_W'(k + 1) == used_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_pos_ff   <= s0_pos_ff;
      s1_first_ff <= s1_first_in;
      s1_last_ff  <= s1_last_in;
   end

   // stage 2: pick the neighboring stops and form the distances
   logic [STOP_W-1:0]          hi_word;
   logic [STOP_W-1:0]          lo_word;
   logic [STOP_W-1:0]          last_word;
   logic [STOP_W-1:0]          end_word;
   logic                       flat;
   logic                       s2_valid_ff;
   logic                       s2_flat_ff;
   logic [STOP_W-1:0]          s2_end_ff;
   logic [STOP_W-1:0]          s2_hi_ff;
   logic [STOP_W-1:0]          s2_lo_ff;
   logic [POS_W-1:0]           s2_a_ff;
   logic [POS_W-1:0]           s2_b_ff;
   logic [POS_W-1:0]           s2_span_ff;

   always_comb begin
      hi_word   = '0;
      lo_word   = '0;
      last_word = '0;
      for (int k = 0; k < MAX_STOPS; k++) begin
         if (s1_first_ff[k]) begin
            hi_word = hi_word | stop_ff[k];
         end
         if (s1_last_ff[k]) begin
            last_word = last_word | stop_ff[k];
         end
      end
      for (int k = 1; k < MAX_STOPS; k++) begin
         if (s1_first_ff[k]) begin
            lo_word = lo_word | stop_ff[k-1];
         end
      end
      // before the first stop or past the last one the color is held
      flat     = s1_first_ff[0] | ~(|s1_first_ff);
      end_word = s1_first_ff[0] ? stop_ff[0] : last_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_flat_ff <= flat;
      s2_end_ff  <= end_word;
      s2_hi_ff   <= hi_word;
      s2_lo_ff   <= lo_word;
      s2_a_ff    <= s1_pos_ff - stop_pos(lo_word);
      s2_b_ff    <= stop_pos(hi_word) - s1_pos_ff;
      s2_span_ff <= stop_pos(hi_word) - stop_pos(lo_word);
   end

   // stage 3: weighted sum per channel; a held color divides by one
   div_req_type s3_req_in;
   div_req_type s3_req_ff;
   logic        s3_valid_ff;

   always_comb begin
      logic [NUM_W-1:0] prod_hi;
      logic [NUM_W-1:0] prod_lo;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         prod_hi = NUM_W'(stop_chan(s2_hi_ff, ch)) * NUM_W'(s2_a_ff);
         prod_lo = NUM_W'(stop_chan(s2_lo_ff, ch)) * NUM_W'(s2_b_ff);
         if (s2_flat_ff) begin
            s3_req_in.num[ch] = NUM_W'(stop_chan(s2_end_ff, ch));
         end else begin
            s3_req_in.num[ch] = prod_hi + prod_lo;
         end
      end
      s3_req_in.span = s2_flat_ff ? POS_W'(1) : s2_span_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_req_ff <= s3_req_in;
   end

   // divide stages
   quot_vec_type quot;

   gcr_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_req    (s3_req_ff),
      .out_valid (rsp_valid),
      .out_quot  (quot)
   );

   assign rsp_red   = quot[0];
   assign rsp_green = quot[1];
   assign rsp_blue  = quot[2];
   assign rsp_alpha = quot[3];

   // at most one upper stop is chosen
   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot0(s1_first_ff))
      else $error("more than one upper stop selected");

   a_last_onehot: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot(s1_last_ff))
      else $error("last used stop not unique");

   // the position lies in the chosen interval: lower at or below, upper strictly above
   a_in_span: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_flat_ff) |-> (s2_a_ff < s2_span_ff))
      else $error("position outside the selected stop interval");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LATENCY rsp_valid)
      else $error("result missing after a position transfer");

endmodule

`default_nettype wire
